FILE: src/counting_semaphore_table_unit_assert.svh
// assertion macros shared by the checker of the semaphore table unit
// no dependencies; every property is clocked and gated by the active-low reset
`ifndef COUNTING_SEMAPHORE_TABLE_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_UNIT_ASSERT_SVH

// property must hold at every rising edge outside reset
`define CSEM_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication form: antecedent at an edge implies consequent sequence
`define CSEM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) else $error(msg);

`endif

FILE: src/csem_pkg.sv
// shared types and constants of the counting semaphore table unit
// no dependencies; used by the top level, its checker and the testbench
`default_nettype none

package csem_pkg;

  localparam int NumSemsDefault    = 16;
  localparam int QueueDepthDefault = 8;

  // stream payload widths
  localparam int ActionW  = 2;
  localparam int IndexW   = 4;
  localparam int IvalW    = 15;
  localparam int ProcW    = 4;
  localparam int StatusW  = 2;
  localparam int InDataW  = 24;
  localparam int OutDataW = 16;

  localparam int ValW = 16;
  localparam logic signed [ValW-1:0] ValMax = 16'sh7fff;
  localparam logic signed [ValW-1:0] ValMin = 16'sh8000;

  localparam logic [1:0] UseInit = 2'd2;
  localparam logic [1:0] UseFree = 2'd0;

  typedef enum logic [ActionW-1:0] {
    ACT_INIT    = 2'd0,
    ACT_POST    = 2'd1,
    ACT_WAIT    = 2'd2,
    ACT_DESTROY = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK    = 2'd0,
    STS_BAD   = 2'd1,
    STS_QFULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

endpackage

`default_nettype wire

FILE: src/counting_semaphore_table_unit.sv
// Counting semaphore table: request channel s_axis, result channel m_axis.
// s_axis_tuser carries the action (init, post, wait, destroy); s_axis_tdata
// carries sem_index, init_value and caller_id. m_axis_tdata returns one
// result per request: status, slot_given, wake_valid, woken_id, caller_blocks.
// When a request is taken, the slot's count value and the head waiter are
// read from their memories; the compute step then computes, writes back and
// loads the output register, and it waits while the output register is full.
// Both memories are read through registers. With a free output register
// m_axis_tvalid rises as the compute step loads the output register, and the
// result can be taken from then on.
// A new request is taken while a result still waits on m_axis; if the
// receiver stalls, the second request holds in its compute step until the
// output register drains, and s_axis_tready stays low meanwhile.
// Reset frees every slot and empties every wait queue at once; count values
// and waiters are undefined until written by init or a blocking wait.
// Init takes the lowest free slot; a bad or unused slot gives status bad,
// and a blocking wait on a full queue gives status queue full.
`default_nettype none

module counting_semaphore_table_unit #(
  parameter int NUM_SEMS    = csem_pkg::NumSemsDefault,
  parameter int QUEUE_DEPTH = csem_pkg::QueueDepthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  // [3:0] sem_index, [18:4] init_value, [22:19] caller_id, [23] zero
  input  wire logic [csem_pkg::InDataW-1:0] s_axis_tdata,
  // [1:0] action
  input  wire logic [csem_pkg::ActionW-1:0] s_axis_tuser,
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [1:0] status, [5:2] slot_given, [6] wake_valid, [10:7] woken_id,
  // [11] caller_blocks, [15:12] zero
  output      logic [csem_pkg::OutDataW-1:0] m_axis_tdata
);

  import csem_pkg::*;

  localparam int SemW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QposW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FillW = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW  = FillW + 1;
  localparam int Words = NUM_SEMS * QUEUE_DEPTH;
  localparam int AddrW = (Words > 1) ? $clog2(Words) : 1;

  // request fields
  logic [IndexW-1:0] sem_index;
  logic [IvalW-1:0]  init_value;
  logic [ProcW-1:0]  caller_id;
  assign sem_index  = s_axis_tdata[3:0];
  assign init_value = s_axis_tdata[18:4];
  assign caller_id  = s_axis_tdata[22:19];

  state_e state_q, state_d;

  // per-slot control state, cleared by reset
  logic [1:0]       use_q  [NUM_SEMS];
  logic [QposW-1:0] head_q [NUM_SEMS];
  logic [FillW-1:0] fill_q [NUM_SEMS];

  // memories, undefined until written
  logic signed [ValW-1:0] cnt_mem [NUM_SEMS];
  logic [ProcW-1:0]       wtr_mem [Words];
  logic signed [ValW-1:0] cnt_rd_q;
  logic [ProcW-1:0]       wtr_rd_q;

  // captured request
  action_e          act_q;
  logic [SemW-1:0]  sel_q;
  logic             live_q;
  logic [IvalW-1:0] ival_q;
  logic [ProcW-1:0] caller_q;

  // output register
  logic              out_valid_q;
  logic [StatusW-1:0] sts_q, sts_d;
  logic [IndexW-1:0] slot_q, slot_d;
  logic              wv_q, wv_d;
  logic [ProcW-1:0]  wid_q, wid_d;
  logic              blk_q, blk_d;

  logic            s_accept, exec_go, in_range, live_in;
  logic [SemW-1:0] sel_in;
  logic [AddrW-1:0] rd_addr;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign exec_go       = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);

  assign in_range = (32'(sem_index) < 32'(NUM_SEMS));
  assign sel_in   = in_range ? SemW'(sem_index) : '0;
  assign live_in  = in_range && (use_q[sel_in] != UseFree);
  assign rd_addr  = AddrW'(sel_in) * AddrW'(QUEUE_DEPTH) + AddrW'(head_q[sel_in]);

  // lowest free slot
  logic            free_found;
  logic [SemW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (use_q[i] == UseFree) begin
        free_found = 1'b1;
        free_idx   = SemW'(i);
      end
    end
  end

  // queue positions of the addressed slot
  logic [QposW-1:0] head_cur, head_nxt;
  logic [FillW-1:0] fill_cur;
  logic [SumW-1:0]  tail_sum;
  logic [QposW-1:0] tail_pos;
  logic [AddrW-1:0] wr_addr;
  assign head_cur = head_q[sel_q];
  assign fill_cur = fill_q[sel_q];
  assign head_nxt = (head_cur == QposW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + QposW'(1);
  assign tail_sum = SumW'(head_cur) + SumW'(fill_cur);
  assign tail_pos = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
                    QposW'(tail_sum - SumW'(QUEUE_DEPTH)) : QposW'(tail_sum);
  assign wr_addr  = AddrW'(sel_q) * AddrW'(QUEUE_DEPTH) + AddrW'(tail_pos);

  // compute step
  logic signed [ValW-1:0] val_inc, val_dec;
  logic                   cnt_we, wtr_we;
  logic [SemW-1:0]        cnt_wa;
  logic signed [ValW-1:0] cnt_wd;
  logic                   do_init, do_pop, do_push, do_destroy;

  assign val_inc = (cnt_rd_q != ValMax) ? cnt_rd_q + 16'sd1 : cnt_rd_q;
  assign val_dec = (cnt_rd_q != ValMin) ? cnt_rd_q - 16'sd1 : cnt_rd_q;

  always_comb begin
    sts_d      = STS_OK;
    slot_d     = '0;
    wv_d       = 1'b0;
    wid_d      = '0;
    blk_d      = 1'b0;
    cnt_we     = 1'b0;
    wtr_we     = 1'b0;
    cnt_wa     = sel_q;
    cnt_wd     = cnt_rd_q;
    do_init    = 1'b0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    do_destroy = 1'b0;
    unique case (act_q)
      ACT_INIT: begin
        if (free_found) begin
          do_init = 1'b1;
          cnt_we  = 1'b1;
          cnt_wa  = free_idx;
          cnt_wd  = $signed({1'b0, ival_q});
          slot_d  = IndexW'(free_idx);
        end else begin
          sts_d = STS_BAD;
        end
      end
      ACT_POST: begin
        if (!live_q) begin
          sts_d = STS_BAD;
        end else begin
          cnt_we = 1'b1;
          cnt_wd = val_inc;
          if (val_inc <= 16'sd0 && fill_cur != '0) begin
            do_pop = 1'b1;
            wv_d   = 1'b1;
            wid_d  = wtr_rd_q;
          end
        end
      end
      ACT_WAIT: begin
        if (!live_q) begin
          sts_d = STS_BAD;
        end else if (val_dec < 16'sd0) begin
          if (fill_cur >= FillW'(QUEUE_DEPTH)) begin
            sts_d = STS_QFULL;
          end else begin
            do_push = 1'b1;
            wtr_we  = 1'b1;
            cnt_we  = 1'b1;
            cnt_wd  = val_dec;
            blk_d   = 1'b1;
          end
        end else begin
          cnt_we = 1'b1;
          cnt_wd = val_dec;
        end
      end
      ACT_DESTROY: begin
        if (!live_q) begin
          sts_d = STS_BAD;
        end else begin
          do_destroy = 1'b1;
        end
      end
      default: begin
        sts_d = STS_BAD;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        use_q[i]  <= UseFree;
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (exec_go) begin
      if (do_init) begin
        use_q[free_idx]  <= UseInit;
        head_q[free_idx] <= '0;
        fill_q[free_idx] <= '0;
      end
      if (do_pop) begin
        head_q[sel_q] <= head_nxt;
        fill_q[sel_q] <= fill_cur - FillW'(1);
      end
      if (do_push) begin
        fill_q[sel_q] <= fill_cur + FillW'(1);
      end
      if (do_destroy) begin
        use_q[sel_q] <= use_q[sel_q] - 2'd1;
      end
    end
  end

  // count and waiter memories: read at accept, write back in the compute step
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cnt_rd_q <= cnt_mem[sel_in];
      wtr_rd_q <= wtr_mem[rd_addr];
    end
    if (exec_go && cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (exec_go && wtr_we) begin
      wtr_mem[wr_addr] <= caller_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      act_q    <= action_e'(s_axis_tuser);
      sel_q    <= sel_in;
      live_q   <= live_in;
      ival_q   <= init_value;
      caller_q <= caller_id;
    end
    if (exec_go) begin
      sts_q  <= sts_d;
      slot_q <= slot_d;
      wv_q   <= wv_d;
      wid_q  <= wid_d;
      blk_q  <= blk_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, blk_q, wid_q, wv_q, slot_q, sts_q};

endmodule

`default_nettype wire

FILE: src/csem_checker.sv
// port-level checker for the counting semaphore table unit, bound to the top
// depends on csem_pkg and counting_semaphore_table_unit_assert.svh
`default_nettype none

`include "counting_semaphore_table_unit_assert.svh"

module csem_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [csem_pkg::OutDataW-1:0] m_axis_tdata
);

  import csem_pkg::*;

  logic s_acc, out_free;
  logic [StatusW-1:0] sts;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign sts      = m_axis_tdata[1:0];

  // a stalled result holds
  `CSEM_ASSERT_IMP(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata)), "result changed while stalled")

  // one request at a time: ready drops right after a request is taken
  `CSEM_ASSERT_IMP(a_one_at_a_time, clk_i, rst_ni, s_acc, ##1 !s_axis_tready, "request taken while another is in work")

  // with a free output register the result shows once the compute step has run
  `CSEM_ASSERT_IMP(a_latency, clk_i, rst_ni, s_acc && out_free, ##2 m_axis_tvalid, "result late")

  // a wake or a block only comes with status ok, never both in one result
  `CSEM_ASSERT(a_flags, clk_i, rst_ni, !m_axis_tvalid || ((!m_axis_tdata[6] || sts == STS_OK) && (!m_axis_tdata[11] || sts == STS_OK) && !(m_axis_tdata[6] && m_axis_tdata[11])), "result flags disagree with status")

endmodule

bind counting_semaphore_table_unit csem_checker u_csem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: test/counting_semaphore_table_unit_tb.sv
`timescale 1ns / 1ps
// testbench of counting_semaphore_table_unit: directed requests, then random
// requests, checked against a behavioral copy of the semaphore table; uses csem_pkg

module testbench;
  import csem_pkg::*;

  localparam int NUM_SLOTS   = NumSemsDefault;
  localparam int WAIT_DEPTH  = QueueDepthDefault;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  slot;
    logic               wake;
    logic [ProcW-1:0]   woken;
    logic               blocks;
  } sem_result_t;

  typedef struct {
    action_e          act;
    logic [IndexW-1:0] idx;
    logic [IvalW-1:0]  ival;
    logic [ProcW-1:0]  caller;
    bit               typed;
    sem_result_t      res;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [ActionW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // table copy used for prediction
  logic [1:0]    slot_uses [NUM_SLOTS];
  int            sem_val [NUM_SLOTS];
  logic [3:0]    waiter_mem [NUM_SLOTS][WAIT_DEPTH];
  int            waiter_head [NUM_SLOTS];
  int            waiters_held [NUM_SLOTS];

  sem_result_t   pending_results[$];
  script_row_t   script_q[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int            hold_asks = 0;
  int            hold_seen = 0;
  int            hold_left = 0;

  always #5 clk_i = ~clk_i;

  counting_semaphore_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic sem_result_t outcome(logic [StatusW-1:0] st, logic [IndexW-1:0] slot,
                                          logic wake, logic [ProcW-1:0] woken,
                                          logic blocks);
    sem_result_t r;
    r.status = st;
    r.slot   = slot;
    r.wake   = wake;
    r.woken  = woken;
    r.blocks = blocks;
    return r;
  endfunction

  // applies one request to the table copy and returns its result
  function automatic sem_result_t apply_semaphore_request(action_e act, logic [3:0] idx,
                                                          logic [14:0] ival,
                                                          logic [3:0] caller);
    sem_result_t r;
    int          nv;
    int          pos;
    r = outcome(STS_OK, '0, 1'b0, '0, 1'b0);
    if (act == ACT_INIT) begin
      r.status = STS_BAD;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_uses[i] == UseFree) begin
          slot_uses[i]    = UseInit;
          sem_val[i]      = int'(ival);
          waiter_head[i]  = 0;
          waiters_held[i] = 0;
          r.status        = STS_OK;
          r.slot          = i[3:0];
          break;
        end
      end
    end else if (int'(idx) >= NUM_SLOTS || slot_uses[idx] == UseFree) begin
      r.status = STS_BAD;
    end else begin
      case (act)
        ACT_POST: begin
          if (sem_val[idx] < int'(ValMax)) sem_val[idx]++;
          if (sem_val[idx] <= 0 && waiters_held[idx] != 0) begin
            r.wake           = 1'b1;
            r.woken          = waiter_mem[idx][waiter_head[idx]];
            waiter_head[idx] = (waiter_head[idx] + 1) % WAIT_DEPTH;
            waiters_held[idx]--;
          end
        end
        ACT_WAIT: begin
          nv = (sem_val[idx] > int'(ValMin)) ? sem_val[idx] - 1 : int'(ValMin);
          if (nv >= 0) begin
            sem_val[idx] = nv;
          end else if (waiters_held[idx] >= WAIT_DEPTH) begin
            r.status = STS_QFULL;
          end else begin
            pos                  = (waiter_head[idx] + waiters_held[idx]) % WAIT_DEPTH;
            waiter_mem[idx][pos] = caller;
            waiters_held[idx]++;
            sem_val[idx]         = nv;
            r.blocks             = 1'b1;
          end
        end
        default: slot_uses[idx] = slot_uses[idx] - 2'd1;
      endcase
    end
    return r;
  endfunction

  task automatic add_row(action_e act, logic [3:0] idx, logic [14:0] ival, logic [3:0] caller,
                         bit typed, sem_result_t res);
    script_row_t row;
    row.act    = act;
    row.idx    = idx;
    row.ival   = ival;
    row.caller = caller;
    row.typed  = typed;
    row.res    = res;
    script_q.push_back(row);
  endtask

  // offers one request and books its expected result once it is taken
  task automatic send_request(action_e act, logic [3:0] idx, logic [14:0] ival,
                              logic [3:0] caller, bit typed, sem_result_t typed_res);
    sem_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, caller, ival, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_semaphore_request(act, idx, ival, caller);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen     <= hold_asks;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sem_result_t got;
    sem_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.slot   = m_axis_tdata[5:2];
      got.wake   = m_axis_tdata[6];
      got.woken  = m_axis_tdata[10:7];
      got.blocks = m_axis_tdata[11];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no request pending: status %0d slot %0d wake %0d",
                   $realtime, got.status, got.slot, got.wake);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch: expected status %0d slot %0d wake %0d woken %0d ",
                      "blocks %0d, got status %0d slot %0d wake %0d woken %0d blocks %0d"},
                     $realtime, want.status, want.slot, want.wake, want.woken, want.blocks,
                     got.status, got.slot, got.wake, got.woken, got.blocks);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int          live_slots[$];
    int          n;
    int          init_w;
    int          destroy_w;
    int          pick;
    bit          fill_mode;
    action_e     act;
    logic [3:0]  idx;
    logic [14:0] ival;
    sem_result_t blocked;
    sem_result_t bad;
    sem_result_t plain;

    foreach (slot_uses[i]) begin
      slot_uses[i]    = UseFree;
      waiter_head[i]  = 0;
      waiters_held[i] = 0;
    end
    blocked = outcome(STS_OK, '0, 1'b0, '0, 1'b1);
    bad     = outcome(STS_BAD, '0, 1'b0, '0, 1'b0);
    plain   = outcome(STS_OK, '0, 1'b0, '0, 1'b0);

    add_row(ACT_POST,    4'd0,  '0,        '0,    1'b1, bad);
    add_row(ACT_WAIT,    4'd15, '0,        4'd15, 1'b1, bad);
    add_row(ACT_DESTROY, 4'd7,  '0,        '0,    1'b1, bad);
    add_row(ACT_INIT,    4'd9,  15'd0,     '0,    1'b1, plain);
    add_row(ACT_INIT,    4'd0,  15'h7fff,  '0,    1'b1,
            outcome(STS_OK, 4'd1, 1'b0, '0, 1'b0));
    // post at the top of the range saturates
    add_row(ACT_POST,    4'd1,  '0,        '0,    1'b1, plain);
    add_row(ACT_WAIT,    4'd1,  '0,        4'd15, 1'b1, plain);
    // fill the wait queue of slot 0
    add_row(ACT_WAIT,    4'd0,  '0,        4'd15, 1'b1, blocked);
    add_row(ACT_WAIT,    4'd0,  '0,        4'd0,  1'b1, blocked);
    for (int c = 1; c <= 6; c++)
      add_row(ACT_WAIT, 4'd0, '0, c[3:0], 1'b1, blocked);
    add_row(ACT_WAIT,    4'd0,  '0,        4'd9,  1'b1,
            outcome(STS_QFULL, '0, 1'b0, '0, 1'b0));
    add_row(ACT_POST,    4'd0,  '0,        '0,    1'b1,
            outcome(STS_OK, '0, 1'b1, 4'd15, 1'b0));
    add_row(ACT_POST,    4'd0,  '0,        '0,    1'b1,
            outcome(STS_OK, '0, 1'b1, 4'd0, 1'b0));
    // write position wraps around the queue
    add_row(ACT_WAIT,    4'd0,  '0,        4'd10, 1'b0, plain);
    add_row(ACT_DESTROY, 4'd0,  '0,        '0,    1'b1, plain);
    add_row(ACT_DESTROY, 4'd0,  '0,        '0,    1'b1, plain);
    add_row(ACT_POST,    4'd0,  '0,        '0,    1'b1, bad);
    add_row(ACT_INIT,    4'd3,  15'h2aaa,  '0,    1'b1, plain);
    add_row(ACT_DESTROY, 4'd1,  '0,        '0,    1'b0, plain);
    add_row(ACT_DESTROY, 4'd1,  '0,        '0,    1'b0, plain);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 15;
    stall_pct    <= 15;
    foreach (script_q[i])
      send_request(script_q[i].act, script_q[i].idx, script_q[i].ival, script_q[i].caller,
                   script_q[i].typed, script_q[i].res);

    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      // sender pauses until every result is back
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 86 : 15) : 0;
      stall_pct    <= (ph == 2) ? 86 : ((ph == 3) ? 15 : 0);
      // long receiver hold-off while requests keep coming
      if (ph == 0) hold_asks <= hold_asks + 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        fill_mode = ((n / 120) % 2) == 0;
        init_w    = fill_mode ? 30 : 8;
        destroy_w = fill_mode ? 10 : 32;
        pick      = $urandom_range(99);
        if (pick < init_w) act = ACT_INIT;
        else if (pick < init_w + destroy_w) act = ACT_DESTROY;
        else if ($urandom_range(99) < (fill_mode ? 60 : 40)) act = ACT_WAIT;
        else act = ACT_POST;

        live_slots.delete();
        foreach (slot_uses[i])
          if (slot_uses[i] != UseFree) live_slots.push_back(i);
        if (live_slots.size() != 0 && $urandom_range(99) < 88) begin
          // half the traffic on one slot so its queue fills up
          if ($urandom_range(1) == 0) idx = 4'(live_slots[0]);
          else idx = 4'(live_slots[$urandom_range(live_slots.size() - 1)]);
        end else begin
          idx = 4'($urandom_range(15));
        end

        pick = $urandom_range(99);
        if (pick < 70) ival = 15'($urandom_range(3));
        else if (pick < 90) ival = 15'($urandom_range(32767));
        else ival = 15'h7fff;

        send_request(act, idx, ival, 4'($urandom_range(15)), 1'b0, plain);
        n++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
